// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the oriented box fit block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define OBF_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define OBF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/obf_pkg.sv =====
// Shared constants and types of the oriented box fit block.
`timescale 1ns / 1ps
package obf_pkg;

    localparam int PAD_BITS       = 17;
    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ROT_ROW_0  = 2'd0,
        REG_ROT_ROW_1  = 2'd1,
        REG_ROT_ROW_2  = 2'd2,
        REG_PAD_MARGIN = 2'd3
    } cfg_reg_t;

endpackage

// ===== rtl/obf_cfg_if.sv =====
// Configuration write channel: register index and data with valid/ready.
`timescale 1ns / 1ps
interface obf_cfg_if #(
    parameter int DATA_BITS = 54
);
    import obf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [DATA_BITS-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/obf_vertex_if.sv =====
// Vertex input channel: mesh frame coordinates and last flag with valid/ready.
`timescale 1ns / 1ps
interface obf_vertex_if #(
    parameter int COORD_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] vertex_z;
    logic                         last_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                    output last_vertex, input ready);
    modport sink (input valid, input vertex_x, input vertex_y, input vertex_z,
                  input last_vertex, output ready);
endinterface

// ===== rtl/obf_box_if.sv =====
// Box result channel: center and half-widths with valid/ready.
`timescale 1ns / 1ps
interface obf_box_if #(
    parameter int COORD_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
    logic [COORD_BITS-2:0]        half_width_x;
    logic [COORD_BITS-2:0]        half_width_y;
    logic [COORD_BITS-2:0]        half_width_z;

    modport source (output valid, output center_x, output center_y, output center_z,
                    output half_width_x, output half_width_y, output half_width_z,
                    input ready);
    modport sink (input valid, input center_x, input center_y, input center_z,
                  input half_width_x, input half_width_y, input half_width_z,
                  output ready);
endinterface

// ===== rtl/oriented_box_bounds_fit.sv =====
// Oriented box fit over a vertex stream, with box axes fixed by configuration.
// Takes one vertex per clock. A vertex enters the box frame through the
// transposed rotation, updates the per-axis min/max, and the vertex flagged
// last_vertex closes the set: its result (center rotated back to the mesh
// frame, padded half-widths) leaves on box after the operand, product and
// rounding registers of the first rotation unit, the bounds result register
// and those of the second unit. Only a last vertex is held by the bounds;
// the input stalls only while such a vertex finds every result register up
// to box full. Write configuration only while no set is in flight.
`timescale 1ns / 1ps
module oriented_box_bounds_fit #(
    parameter int COORD_BITS = 32,
    parameter int ROT_BITS   = 18
) (
    input  logic         clk,
    input  logic         rst_n,
    obf_cfg_if.sink      cfg,
    obf_vertex_if.sink   vertex,
    obf_box_if.source    box
);
    import obf_pkg::*;

    `include "assert_macros.svh"

    localparam int STATE_BITS = COORD_BITS + 2;
    localparam int HALF_BITS  = COORD_BITS - 1;

    logic [2:0][2:0][ROT_BITS-1:0] rot;
    logic [2:0][2:0][ROT_BITS-1:0] rot_tr;
    logic [PAD_BITS-1:0]           pad;

    logic [2:0][COORD_BITS-1:0]    vtx_vec;
    logic                          q_valid;
    logic                          q_ready;
    logic [2:0][STATE_BITS-1:0]    q_vec;
    logic                          q_last;

    logic                          mid_valid;
    logic                          mid_ready;
    logic [2:0][STATE_BITS-1:0]    mid_vec;
    logic [2:0][HALF_BITS-1:0]     half_vec;

    logic [2:0][COORD_BITS-1:0]    center_vec;
    logic [2:0][HALF_BITS-1:0]     out_half;

    obf_cfg_regs #(
        .ROT_BITS (ROT_BITS)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .rot   (rot),
        .pad   (pad)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rot_tr[k][i] = rot[i][k];
            end
        end
    end

    assign vtx_vec[0] = vertex.vertex_x;
    assign vtx_vec[1] = vertex.vertex_y;
    assign vtx_vec[2] = vertex.vertex_z;

    // Mesh frame to box frame.
    obf_rotate #(
        .IN_BITS   (COORD_BITS),
        .ROT_BITS  (ROT_BITS),
        .OUT_BITS  (STATE_BITS),
        .SIDE_BITS (1)
    ) u_to_box (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat       (rot),
        .in_valid  (vertex.valid),
        .in_ready  (vertex.ready),
        .in_vec    (vtx_vec),
        .in_side   (vertex.last_vertex),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_vec   (q_vec),
        .out_side  (q_last)
    );

    obf_bounds #(
        .STATE_BITS (STATE_BITS),
        .HALF_BITS  (HALF_BITS)
    ) u_bounds (
        .clk       (clk),
        .rst_n     (rst_n),
        .pad       (pad),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q         (q_vec),
        .q_last    (q_last),
        .res_valid (mid_valid),
        .res_ready (mid_ready),
        .mid       (mid_vec),
        .half      (half_vec)
    );

    // Box center back to the mesh frame; half-widths ride alongside.
    obf_rotate #(
        .IN_BITS   (STATE_BITS),
        .ROT_BITS  (ROT_BITS),
        .OUT_BITS  (COORD_BITS),
        .SIDE_BITS (3 * HALF_BITS)
    ) u_to_mesh (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat       (rot_tr),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_vec    (mid_vec),
        .in_side   (half_vec),
        .out_valid (box.valid),
        .out_ready (box.ready),
        .out_vec   (center_vec),
        .out_side  (out_half)
    );

    assign box.center_x     = center_vec[0];
    assign box.center_y     = center_vec[1];
    assign box.center_z     = center_vec[2];
    assign box.half_width_x = out_half[0];
    assign box.half_width_y = out_half[1];
    assign box.half_width_z = out_half[2];

    `OBF_ASSERT_IMPLY(a_stall_only_last, clk, rst_n, q_valid && !q_ready, q_last, "bounds stalled a vertex that does not close a set")
    `OBF_ASSERT(a_result_after_last, clk, rst_n, !$rose(mid_valid) || $past(q_valid && q_ready && q_last), "bounds result without a closing vertex")
    `OBF_ASSERT_IMPLY(a_half_covers_pad, clk, rst_n, mid_valid, ((&half_vec[0]) || ((COORD_BITS+PAD_BITS)'(half_vec[0]) >= (COORD_BITS+PAD_BITS)'(pad))) && ((&half_vec[1]) || ((COORD_BITS+PAD_BITS)'(half_vec[1]) >= (COORD_BITS+PAD_BITS)'(pad))) && ((&half_vec[2]) || ((COORD_BITS+PAD_BITS)'(half_vec[2]) >= (COORD_BITS+PAD_BITS)'(pad))), "half-width below pad margin")

endmodule

// ===== rtl/obf_cfg_regs.sv =====
// Configuration registers: box rotation rows and pad margin.
`timescale 1ns / 1ps
module obf_cfg_regs #(
    parameter int ROT_BITS = 18
) (
    input  logic                          clk,
    input  logic                          rst_n,
    obf_cfg_if.sink                       cfg,
    output logic [2:0][2:0][ROT_BITS-1:0] rot,
    output logic [obf_pkg::PAD_BITS-1:0]  pad
);
    import obf_pkg::*;

    localparam logic [ROT_BITS-1:0] ROT_ONE = ROT_BITS'(1) << (ROT_BITS - 2);

    logic [2:0][2:0][ROT_BITS-1:0] rot_reg;
    logic [PAD_BITS-1:0]           pad_reg;
    logic                          wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    rot_reg[i][j] <= (i == j) ? ROT_ONE : '0;
                end
            end
            pad_reg <= PAD_BITS'(1);
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_ROT_ROW_0:  rot_reg[0] <= cfg.data[3*ROT_BITS-1:0];
                REG_ROT_ROW_1:  rot_reg[1] <= cfg.data[3*ROT_BITS-1:0];
                REG_ROT_ROW_2:  rot_reg[2] <= cfg.data[3*ROT_BITS-1:0];
                REG_PAD_MARGIN: pad_reg    <= cfg.data[PAD_BITS-1:0];
                default:        pad_reg    <= pad_reg;
            endcase
        end
    end

    assign rot = rot_reg;
    assign pad = pad_reg;

endmodule

// ===== rtl/obf_rotate.sv =====
// Three-stage 3x3 fixed-point rotation: operand, product and rounded result registers.
`timescale 1ns / 1ps
module obf_rotate #(
    parameter int IN_BITS   = 32,
    parameter int ROT_BITS  = 18,
    parameter int OUT_BITS  = 34,
    parameter int SIDE_BITS = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // out[k] = sum over i of in[i] * mat[i][k]
    input  logic [2:0][2:0][ROT_BITS-1:0] mat,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0][IN_BITS-1:0]       in_vec,
    input  logic [SIDE_BITS-1:0]          in_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0][OUT_BITS-1:0]      out_vec,
    output logic [SIDE_BITS-1:0]          out_side
);
    localparam int FRAC = ROT_BITS - 2;
    localparam int PW   = IN_BITS + ROT_BITS;
    localparam int SW   = PW + 2;
    localparam int RW   = SW - FRAC;

    localparam logic signed [SW-1:0] HALF_LSB = SW'(1) <<< (FRAC - 1);
    localparam logic signed [RW-1:0] OUT_MAX  = (RW'(1) <<< (OUT_BITS - 1)) - RW'(1);
    localparam logic signed [RW-1:0] OUT_MIN  = ~OUT_MAX;

    logic                      a_valid_reg;
    logic [2:0][IN_BITS-1:0]   a_vec_reg;
    logic [SIDE_BITS-1:0]      a_side_reg;
    logic                      p_valid_reg;
    logic signed [PW-1:0]      p_reg [3][3];
    logic signed [PW-1:0]      p_next [3][3];
    logic [SIDE_BITS-1:0]      p_side_reg;
    logic                      o_valid_reg;
    logic [2:0][OUT_BITS-1:0]  o_vec_reg;
    logic [2:0][OUT_BITS-1:0]  o_vec_next;
    logic [SIDE_BITS-1:0]      o_side_reg;

    logic                      a_ready;
    logic                      p_ready;
    logic                      o_ready;
    logic signed [SW-1:0]      acc [3];
    logic signed [RW-1:0]      rnd [3];

    assign o_ready  = !o_valid_reg || out_ready;
    assign p_ready  = !p_valid_reg || o_ready;
    assign a_ready  = !a_valid_reg || p_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p_next[i][k] = $signed(a_vec_reg[i]) * $signed(mat[i][k]);
            end
        end
    end

    // Round to nearest, ties up, then clamp to the output range.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc[k] = SW'(p_reg[0][k]) + SW'(p_reg[1][k]) + SW'(p_reg[2][k]) + HALF_LSB;
            rnd[k] = RW'(acc[k] >>> FRAC);
            if (rnd[k] > OUT_MAX)
            begin
                o_vec_next[k] = OUT_MAX[OUT_BITS-1:0];
            end
            else if (rnd[k] < OUT_MIN)
            begin
                o_vec_next[k] = OUT_MIN[OUT_BITS-1:0];
            end
            else
            begin
                o_vec_next[k] = rnd[k][OUT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (p_ready)
            begin
                p_valid_reg <= a_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_vec_reg  <= in_vec;
            a_side_reg <= in_side;
        end
        if (a_valid_reg && p_ready)
        begin
            p_reg      <= p_next;
            p_side_reg <= a_side_reg;
        end
        if (p_valid_reg && o_ready)
        begin
            o_vec_reg  <= o_vec_next;
            o_side_reg <= p_side_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_vec   = o_vec_reg;
    assign out_side  = o_side_reg;

endmodule

// ===== rtl/obf_bounds.sv =====
// Running per-axis min/max in the box frame, with midpoint and padded half-width.
`timescale 1ns / 1ps
module obf_bounds #(
    parameter int STATE_BITS = 34,
    parameter int HALF_BITS  = 31
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [obf_pkg::PAD_BITS-1:0]    pad,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  logic [2:0][STATE_BITS-1:0]      q,
    input  logic                            q_last,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic [2:0][STATE_BITS-1:0]      mid,
    output logic [2:0][HALF_BITS-1:0]       half
);
    import obf_pkg::*;

    localparam int S = STATE_BITS;
    localparam logic [S-1:0]        S_MAX    = {1'b0, {(S-1){1'b1}}};
    localparam logic [S-1:0]        S_MIN    = ~S_MAX;
    localparam logic signed [S:0]   HALF_MAX = (S+1)'({HALF_BITS{1'b1}});

    logic [2:0][S-1:0] lo_reg;
    logic [2:0][S-1:0] lo_next;
    logic [2:0][S-1:0] hi_reg;
    logic [2:0][S-1:0] hi_next;
    logic [2:0][S-1:0] fin_lo_reg;
    logic [2:0][S-1:0] fin_hi_reg;
    logic              fin_valid_reg;
    logic              fin_valid_next;
    logic              take;

    logic signed [S:0]   mid_sum [3];
    logic signed [S:0]   span [3];
    logic signed [S-1:0] half_span [3];
    logic signed [S:0]   padded [3];

    // Only a last vertex needs room in the result register.
    assign q_ready = !q_last || !fin_valid_reg || res_ready;
    assign take    = q_valid && q_ready;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lo_next[k] = ($signed(q[k]) < $signed(lo_reg[k])) ? q[k] : lo_reg[k];
            hi_next[k] = ($signed(q[k]) > $signed(hi_reg[k])) ? q[k] : hi_reg[k];
        end
    end

    always_comb
    begin
        fin_valid_next = fin_valid_reg;
        if (take && q_last)
        begin
            fin_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            fin_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg        <= {3{S_MAX}};
            hi_reg        <= {3{S_MIN}};
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            if (take)
            begin
                // Reopen the bounds once a set closes.
                lo_reg <= q_last ? {3{S_MAX}} : lo_next;
                hi_reg <= q_last ? {3{S_MIN}} : hi_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && q_last)
        begin
            fin_lo_reg <= lo_next;
            fin_hi_reg <= hi_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mid_sum[k]   = $signed({fin_hi_reg[k][S-1], fin_hi_reg[k]})
                         + $signed({fin_lo_reg[k][S-1], fin_lo_reg[k]});
            mid[k]       = mid_sum[k][S:1];
            span[k]      = $signed({fin_hi_reg[k][S-1], fin_hi_reg[k]})
                         - $signed({fin_lo_reg[k][S-1], fin_lo_reg[k]});
            half_span[k] = span[k][S:1];
            padded[k]    = $signed({half_span[k][S-1], half_span[k]})
                         + $signed((S+1)'(pad));
            if (padded[k] < 0)
            begin
                half[k] = '0;
            end
            else if (padded[k] > HALF_MAX)
            begin
                half[k] = HALF_MAX[HALF_BITS-1:0];
            end
            else
            begin
                half[k] = padded[k][HALF_BITS-1:0];
            end
        end
    end

    assign res_valid = fin_valid_reg;

endmodule
